### rtl/ps2md_pkg.sv
// Shared types and constants for the PS/2 mouse device responder.
package ps2md_pkg;

    // Input item kinds, carried on s_tuser
    localparam logic [2:0] KIND_CMD    = 3'd0;
    localparam logic [2:0] KIND_MOVE_X = 3'd1;
    localparam logic [2:0] KIND_MOVE_Y = 3'd2;
    localparam logic [2:0] KIND_BUTTON = 3'd3;
    localparam logic [2:0] KIND_SYNC   = 3'd4;

    // Host commands
    localparam logic [7:0] CMD_RESET        = 8'hFF;
    localparam logic [7:0] CMD_GET_ID       = 8'hF2;
    localparam logic [7:0] CMD_STATUS       = 8'hE9;
    localparam logic [7:0] CMD_READ_DATA    = 8'hEB;
    localparam logic [7:0] CMD_SET_RES      = 8'hE8;
    localparam logic [7:0] CMD_SET_RATE     = 8'hF3;
    localparam logic [7:0] CMD_ENABLE       = 8'hF4;
    localparam logic [7:0] CMD_DISABLE      = 8'hF5;
    localparam logic [7:0] CMD_SET_DEFAULTS = 8'hF6;

    // Reply bytes
    localparam logic [7:0] RSP_ACK       = 8'hFA;
    localparam logic [7:0] RSP_SELF_TEST = 8'hAA;
    localparam logic [7:0] RSP_DEVICE_ID = 8'h00;
    localparam logic [7:0] RSP_ZERO      = 8'h00;
    localparam logic [7:0] STATUS_REPORT = 8'h20;

    // Defaults
    localparam logic [7:0] DEFAULT_RES  = 8'd2;
    localparam logic [7:0] DEFAULT_RATE = 8'd100;

    // Movement packet header bits
    localparam logic [7:0] HDR_ALWAYS = 8'h08;
    localparam logic [7:0] HDR_X_NEG  = 8'h10;
    localparam logic [7:0] HDR_Y_NEG  = 8'h20;
    localparam int         STEP_LIMIT = 127;

    // Pending parameter codes
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_RES  = 2'd1;
    localparam logic [1:0] PEND_RATE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPLY,
        ST_PKT
    } state_t;

    typedef enum logic [2:0] {
        RPL_ACK,
        RPL_RESET,
        RPL_ID,
        RPL_STATUS,
        RPL_READ
    } reply_t;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_X,
        PH_Y
    } phase_t;

endpackage

### rtl/ps2_mouse_device_responder.sv
// PS/2 mouse device side: motion accumulation, packet generation, command replies.
// Result bytes are registered in m_tdata_reg; packet bytes use one shared clamp unit.
// An item that emits N bytes (commands 1 to 4, sync 3 to 3*MAX_PACKETS) holds s_tready
// low until its last byte is loaded, one byte per cycle unless m_tready stalls.
// Motion, button, ignored and silent sync items emit nothing; s_tready stays high.
// Reset (aresetn low, synchronous) restores defaults and clears accumulators.
module ps2_mouse_device_responder #(
    parameter int MAX_PACKETS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] cmd_byte, [18:8] motion_delta, [20:19] button_index,
    // [21] button_pressed, [23:22] zero
    input  logic [23:0] s_tdata,
    // [2:0] kind
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte
    output logic [7:0]  m_tdata,
    // [0] to_reply_channel
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    localparam int ACC_LIMIT = ps2md_pkg::STEP_LIMIT * MAX_PACKETS;
    localparam int ACC_W     = $clog2(ACC_LIMIT + 1) + 1;
    localparam int SUM_W     = ((ACC_W > 11) ? ACC_W : 11) + 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX  = SUM_W'(ACC_LIMIT);
    localparam logic signed [SUM_W-1:0] SUM_MIN  = -SUM_W'(ACC_LIMIT);
    localparam logic signed [ACC_W-1:0] STEP_MAX = ACC_W'(ps2md_pkg::STEP_LIMIT);
    localparam logic signed [ACC_W-1:0] STEP_MIN = -ACC_W'(ps2md_pkg::STEP_LIMIT);

    // Input fields
    logic [7:0]         in_cmd;
    logic signed [10:0] in_delta;
    logic [1:0]         in_btn_idx;
    logic               in_btn_pressed;
    logic               s_fire;

    assign in_cmd         = s_tdata[7:0];
    assign in_delta       = s_tdata[18:8];
    assign in_btn_idx     = s_tdata[20:19];
    assign in_btn_pressed = s_tdata[21];

    // State
    ps2md_pkg::state_t state_reg, state_next;
    ps2md_pkg::reply_t rkind_reg, rkind_next;
    ps2md_pkg::phase_t phase_reg, phase_next;
    logic [1:0]              idx_reg, idx_next;
    logic                    reporting_reg, reporting_next;
    logic [7:0]              res_reg, res_next;
    logic [7:0]              rate_reg, rate_next;
    logic [1:0]              pend_reg, pend_next;
    logic [2:0]              btn_reg, btn_next;
    logic signed [ACC_W-1:0] acc_x_reg, acc_x_next;
    logic signed [ACC_W-1:0] acc_y_reg, acc_y_next;
    logic                    zero_pkt_reg, zero_pkt_next;
    logic                    pkt_reply_reg, pkt_reply_next;

    // Output register
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tuser_reg, m_tuser_next;
    logic       m_tlast_reg, m_tlast_next;

    logic       load;
    logic       reply_end;
    logic       pkt_end;
    logic [7:0] reply_byte;

    // Shared clamp/subtract unit
    logic signed [ACC_W-1:0] op;
    logic signed [ACC_W-1:0] step;
    logic signed [ACC_W-1:0] rem;

    // Motion adder
    logic signed [SUM_W-1:0] sum_in_a;
    logic signed [SUM_W-1:0] sum_in_b;
    logic signed [SUM_W-1:0] sum;
    logic signed [ACC_W-1:0] sum_sat;

    assign s_tready = (state_reg == ps2md_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign load     = (state_reg != ps2md_pkg::ST_IDLE) && (!m_tvalid_reg || m_tready);

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

    // Clamp unit operand: X on the X byte, Y otherwise; zero for a read-data packet
    always_comb begin
        if (zero_pkt_reg) begin
            op = '0;
        end else if (phase_reg == ps2md_pkg::PH_X) begin
            op = acc_x_reg;
        end else begin
            op = acc_y_reg;
        end
        if (op > STEP_MAX) begin
            step = STEP_MAX;
        end else if (op < STEP_MIN) begin
            step = STEP_MIN;
        end else begin
            step = op;
        end
        rem = op - step;
    end

    // Saturating motion accumulate (Y is subtracted)
    always_comb begin
        if (s_tuser == ps2md_pkg::KIND_MOVE_X) begin
            sum_in_a = {{(SUM_W-ACC_W){acc_x_reg[ACC_W-1]}}, acc_x_reg};
        end else begin
            sum_in_a = {{(SUM_W-ACC_W){acc_y_reg[ACC_W-1]}}, acc_y_reg};
        end
        sum_in_b = {{(SUM_W-11){in_delta[10]}}, in_delta};
        if (s_tuser == ps2md_pkg::KIND_MOVE_X) begin
            sum = sum_in_a + sum_in_b;
        end else begin
            sum = sum_in_a - sum_in_b;
        end
        if (sum > SUM_MAX) begin
            sum_sat = SUM_MAX[ACC_W-1:0];
        end else if (sum < SUM_MIN) begin
            sum_sat = SUM_MIN[ACC_W-1:0];
        end else begin
            sum_sat = sum[ACC_W-1:0];
        end
    end

    // Reply byte selection and end of the reply list
    always_comb begin
        reply_byte = ps2md_pkg::RSP_ACK;
        reply_end  = 1'b1;
        unique case (rkind_reg)
            ps2md_pkg::RPL_ACK, ps2md_pkg::RPL_READ: begin
                reply_byte = ps2md_pkg::RSP_ACK;
                reply_end  = 1'b1;
            end
            ps2md_pkg::RPL_RESET: begin
                reply_end = (idx_reg == 2'd2);
                if (idx_reg == 2'd1) begin
                    reply_byte = ps2md_pkg::RSP_SELF_TEST;
                end else if (idx_reg == 2'd2) begin
                    reply_byte = ps2md_pkg::RSP_DEVICE_ID;
                end
            end
            ps2md_pkg::RPL_ID: begin
                reply_end = (idx_reg == 2'd1);
                if (idx_reg == 2'd1) begin
                    reply_byte = ps2md_pkg::RSP_DEVICE_ID;
                end
            end
            ps2md_pkg::RPL_STATUS: begin
                reply_end = (idx_reg == 2'd3);
                unique case (idx_reg)
                    2'd1:    reply_byte = reporting_reg ? ps2md_pkg::STATUS_REPORT
                                                        : ps2md_pkg::RSP_ZERO;
                    2'd2:    reply_byte = res_reg;
                    2'd3:    reply_byte = rate_reg;
                    default: reply_byte = ps2md_pkg::RSP_ACK;
                endcase
            end
            default: begin
                reply_byte = ps2md_pkg::RSP_ACK;
                reply_end  = 1'b1;
            end
        endcase
    end

    // Last packet byte: both remainders used up after the Y step
    assign pkt_end = (phase_reg == ps2md_pkg::PH_Y)
                     && (zero_pkt_reg || ((acc_x_reg == '0) && (rem == '0)));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ps2md_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == ps2md_pkg::KIND_CMD) begin
                        state_next = ps2md_pkg::ST_REPLY;
                    end else if (s_tuser == ps2md_pkg::KIND_SYNC && reporting_reg) begin
                        state_next = ps2md_pkg::ST_PKT;
                    end
                end
            end
            ps2md_pkg::ST_REPLY: begin
                if (load && reply_end) begin
                    state_next = (rkind_reg == ps2md_pkg::RPL_READ) ? ps2md_pkg::ST_PKT
                                                                   : ps2md_pkg::ST_IDLE;
                end
            end
            ps2md_pkg::ST_PKT: begin
                if (load && pkt_end) begin
                    state_next = ps2md_pkg::ST_IDLE;
                end
            end
            default: state_next = ps2md_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register next values
    always_comb begin
        rkind_next     = rkind_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        reporting_next = reporting_reg;
        res_next       = res_reg;
        rate_next      = rate_reg;
        pend_next      = pend_reg;
        btn_next       = btn_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        zero_pkt_next  = zero_pkt_reg;
        pkt_reply_next = pkt_reply_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;

        // Accept a transaction
        if (s_fire) begin
            idx_next   = '0;
            phase_next = ps2md_pkg::PH_HEAD;
            unique case (s_tuser)
                ps2md_pkg::KIND_CMD: begin
                    rkind_next = ps2md_pkg::RPL_ACK;
                    if (pend_reg != ps2md_pkg::PEND_NONE) begin
                        if (pend_reg == ps2md_pkg::PEND_RES) begin
                            res_next = in_cmd;
                        end else if (pend_reg == ps2md_pkg::PEND_RATE) begin
                            rate_next = in_cmd;
                        end
                        pend_next = ps2md_pkg::PEND_NONE;
                    end else begin
                        unique case (in_cmd)
                            ps2md_pkg::CMD_RESET: begin
                                rkind_next     = ps2md_pkg::RPL_RESET;
                                reporting_next = 1'b0;
                                res_next       = ps2md_pkg::DEFAULT_RES;
                                rate_next      = ps2md_pkg::DEFAULT_RATE;
                            end
                            ps2md_pkg::CMD_GET_ID: rkind_next = ps2md_pkg::RPL_ID;
                            ps2md_pkg::CMD_STATUS: rkind_next = ps2md_pkg::RPL_STATUS;
                            ps2md_pkg::CMD_READ_DATA: begin
                                rkind_next     = ps2md_pkg::RPL_READ;
                                zero_pkt_next  = 1'b1;
                                pkt_reply_next = 1'b1;
                            end
                            ps2md_pkg::CMD_SET_RES:  pend_next = ps2md_pkg::PEND_RES;
                            ps2md_pkg::CMD_SET_RATE: pend_next = ps2md_pkg::PEND_RATE;
                            ps2md_pkg::CMD_ENABLE:   reporting_next = 1'b1;
                            ps2md_pkg::CMD_DISABLE:  reporting_next = 1'b0;
                            ps2md_pkg::CMD_SET_DEFAULTS: begin
                                reporting_next = 1'b0;
                                res_next       = ps2md_pkg::DEFAULT_RES;
                                rate_next      = ps2md_pkg::DEFAULT_RATE;
                            end
                            default: rkind_next = ps2md_pkg::RPL_ACK;
                        endcase
                    end
                end
                ps2md_pkg::KIND_MOVE_X: acc_x_next = sum_sat;
                ps2md_pkg::KIND_MOVE_Y: acc_y_next = sum_sat;
                ps2md_pkg::KIND_BUTTON: begin
                    unique case (in_btn_idx)
                        2'd0:    btn_next[0] = in_btn_pressed;
                        2'd1:    btn_next[1] = in_btn_pressed;
                        2'd2:    btn_next[2] = in_btn_pressed;
                        default: btn_next    = btn_reg;
                    endcase
                end
                ps2md_pkg::KIND_SYNC: begin
                    zero_pkt_next  = 1'b0;
                    pkt_reply_next = 1'b0;
                    // Without reporting the motion is simply dropped
                    if (!reporting_reg) begin
                        acc_x_next = '0;
                        acc_y_next = '0;
                    end
                end
                default: begin
                    rkind_next = rkind_reg;
                end
            endcase
        end

        // Emit one reply byte
        if (load && state_reg == ps2md_pkg::ST_REPLY) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = reply_byte;
            m_tuser_next  = 1'b1;
            m_tlast_next  = reply_end && (rkind_reg != ps2md_pkg::RPL_READ);
            idx_next      = idx_reg + 2'd1;
        end

        // Emit one packet byte; remainders shrink through the shared unit
        if (load && state_reg == ps2md_pkg::ST_PKT) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = pkt_reply_reg;
            m_tlast_next  = pkt_end;
            unique case (phase_reg)
                ps2md_pkg::PH_HEAD: begin
                    m_tdata_next = ps2md_pkg::HDR_ALWAYS | {5'd0, btn_reg};
                    if (!zero_pkt_reg && acc_x_reg[ACC_W-1]) begin
                        m_tdata_next = m_tdata_next | ps2md_pkg::HDR_X_NEG;
                    end
                    if (!zero_pkt_reg && acc_y_reg[ACC_W-1]) begin
                        m_tdata_next = m_tdata_next | ps2md_pkg::HDR_Y_NEG;
                    end
                    phase_next = ps2md_pkg::PH_X;
                end
                ps2md_pkg::PH_X: begin
                    m_tdata_next = step[7:0];
                    if (!zero_pkt_reg) begin
                        acc_x_next = rem;
                    end
                    phase_next = ps2md_pkg::PH_Y;
                end
                ps2md_pkg::PH_Y: begin
                    m_tdata_next = step[7:0];
                    if (!zero_pkt_reg) begin
                        acc_y_next = rem;
                    end
                    phase_next = ps2md_pkg::PH_HEAD;
                end
                default: phase_next = ps2md_pkg::PH_HEAD;
            endcase
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ps2md_pkg::ST_IDLE;
            rkind_reg     <= ps2md_pkg::RPL_ACK;
            phase_reg     <= ps2md_pkg::PH_HEAD;
            idx_reg       <= '0;
            reporting_reg <= 1'b0;
            res_reg       <= ps2md_pkg::DEFAULT_RES;
            rate_reg      <= ps2md_pkg::DEFAULT_RATE;
            pend_reg      <= ps2md_pkg::PEND_NONE;
            btn_reg       <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            zero_pkt_reg  <= 1'b0;
            pkt_reply_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rkind_reg     <= rkind_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            reporting_reg <= reporting_next;
            res_reg       <= res_next;
            rate_reg      <= rate_next;
            pend_reg      <= pend_next;
            btn_reg       <= btn_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            zero_pkt_reg  <= zero_pkt_next;
            pkt_reply_reg <= pkt_reply_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

### tb/sv/ps2_mouse_device_responder_tb.sv
// Testbench for ps2_mouse_device_responder: directed and random stimulus, self-checking.
`timescale 1ns / 100ps

module ps2_mouse_device_responder_tb;

    localparam int MAX_PACKETS   = 16;
    localparam int ACC_LIMIT     = ps2md_pkg::STEP_LIMIT * MAX_PACKETS;
    localparam int RANDOM_ITEMS  = 115;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_TAIL    = 60;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PRINT_LIMIT   = 40;

    // Kinds the block ignores
    localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
    localparam logic [2:0] KIND_RESERVED_HI = 3'd7;

    // Button indexes
    localparam logic [1:0] IDX_LEFT    = 2'd0;
    localparam logic [1:0] IDX_RIGHT   = 2'd1;
    localparam logic [1:0] IDX_MIDDLE  = 2'd2;
    localparam logic [1:0] IDX_INVALID = 2'd3;

    // Output channels
    localparam logic CH_MOVE  = 1'b0;
    localparam logic CH_REPLY = 1'b1;

    // Command byte with no meaning of its own
    localparam logic [7:0] CMD_UNKNOWN = 8'h5A;

    localparam logic signed [10:0] DELTA_MAX = 11'sd1023;
    localparam logic signed [10:0] DELTA_MIN = -11'sd1024;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    typedef struct {
        logic [7:0] data;
        logic       reply;
        logic       last;
    } host_byte_t;

    // Bytes the host should see, oldest first
    host_byte_t host_bytes_due[$];
    host_byte_t byte_wanted;

    // Predicted device state
    logic       reporting_on;
    logic [7:0] resolution;
    logic [7:0] sample_rate;
    logic [1:0] param_due;
    logic [2:0] buttons;
    int         move_x;
    int         move_y;

    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    bit          hold_request = 1'b0;
    int          hold_left = 0;
    int          rx_mode = 0;
    int          rx_mode_left = 0;

    ps2_mouse_device_responder #(
        .MAX_PACKETS(MAX_PACKETS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic int clamp_to(int v, int lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    function automatic void push_expected(logic [7:0] b, logic reply);
        host_byte_t hb;
        hb.data  = b;
        hb.reply = reply;
        hb.last  = 1'b0;
        host_bytes_due.push_back(hb);
    endfunction

    function automatic void mouse_defaults();
        reporting_on = 1'b0;
        resolution   = ps2md_pkg::DEFAULT_RES;
        sample_rate  = ps2md_pkg::DEFAULT_RATE;
    endfunction

    // Movement packets until the remaining motion is used up, at least one
    function automatic void queue_packets(int dx, int dy, logic reply);
        int         sx;
        int         sy;
        logic [7:0] head;
        do begin
            sx   = clamp_to(dx, ps2md_pkg::STEP_LIMIT);
            sy   = clamp_to(dy, ps2md_pkg::STEP_LIMIT);
            head = ps2md_pkg::HDR_ALWAYS | {5'b0, buttons};
            if (sx < 0) head = head | ps2md_pkg::HDR_X_NEG;
            if (sy < 0) head = head | ps2md_pkg::HDR_Y_NEG;
            push_expected(head, reply);
            push_expected(sx[7:0], reply);
            push_expected(sy[7:0], reply);
            dx -= sx;
            dy -= sy;
        end while (dx != 0 || dy != 0);
    endfunction

    function automatic void predict_mouse_output(logic [2:0] kind, logic [7:0] cmd,
                                                 logic signed [10:0] delta,
                                                 logic [1:0] idx, logic pressed);
        int n_before;
        int d;
        n_before = host_bytes_due.size();
        d = delta;
        case (kind)
            ps2md_pkg::KIND_CMD: begin
                if (param_due != ps2md_pkg::PEND_NONE) begin
                    if (param_due == ps2md_pkg::PEND_RES) resolution = cmd;
                    else if (param_due == ps2md_pkg::PEND_RATE) sample_rate = cmd;
                    param_due = ps2md_pkg::PEND_NONE;
                    push_expected(ps2md_pkg::RSP_ACK, CH_REPLY);
                end else begin
                    push_expected(ps2md_pkg::RSP_ACK, CH_REPLY);
                    case (cmd)
                        ps2md_pkg::CMD_RESET: begin
                            mouse_defaults();
                            push_expected(ps2md_pkg::RSP_SELF_TEST, CH_REPLY);
                            push_expected(ps2md_pkg::RSP_DEVICE_ID, CH_REPLY);
                        end
                        ps2md_pkg::CMD_GET_ID:
                            push_expected(ps2md_pkg::RSP_DEVICE_ID, CH_REPLY);
                        ps2md_pkg::CMD_STATUS: begin
                            push_expected(reporting_on ? ps2md_pkg::STATUS_REPORT
                                                       : ps2md_pkg::RSP_ZERO, CH_REPLY);
                            push_expected(resolution, CH_REPLY);
                            push_expected(sample_rate, CH_REPLY);
                        end
                        ps2md_pkg::CMD_READ_DATA: queue_packets(0, 0, CH_REPLY);
                        ps2md_pkg::CMD_SET_RES: param_due = ps2md_pkg::PEND_RES;
                        ps2md_pkg::CMD_SET_RATE: param_due = ps2md_pkg::PEND_RATE;
                        ps2md_pkg::CMD_ENABLE: reporting_on = 1'b1;
                        ps2md_pkg::CMD_DISABLE: reporting_on = 1'b0;
                        ps2md_pkg::CMD_SET_DEFAULTS: mouse_defaults();
                        default: ;
                    endcase
                end
            end
            ps2md_pkg::KIND_MOVE_X: move_x = clamp_to(move_x + d, ACC_LIMIT);
            ps2md_pkg::KIND_MOVE_Y: move_y = clamp_to(move_y - d, ACC_LIMIT);
            ps2md_pkg::KIND_BUTTON: begin
                if (idx != IDX_INVALID) buttons[idx] = pressed;
            end
            ps2md_pkg::KIND_SYNC: begin
                if (reporting_on) queue_packets(move_x, move_y, CH_MOVE);
                move_x = 0;
                move_y = 0;
            end
            default: ;
        endcase
        if (host_bytes_due.size() > n_before)
            host_bytes_due[host_bytes_due.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Input side: bursts of transactions with random gaps
    // ---------------------------------------------------------------
    task automatic send_item(input logic [2:0] kind, input logic [7:0] cmd,
                             input logic signed [10:0] delta, input logic [1:0] idx,
                             input logic pressed);
        int gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, pressed, idx, delta, cmd};
        s_tuser  = kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_mouse_output(kind, cmd, delta, idx, pressed);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // Unused fields carry random bits
    task automatic send_cmd(input logic [7:0] c);
        send_item(ps2md_pkg::KIND_CMD, c, 11'($urandom), 2'($urandom), 1'($urandom));
    endtask

    task automatic send_motion(input logic [2:0] kind, input logic signed [10:0] d);
        send_item(kind, 8'($urandom), d, 2'($urandom), 1'($urandom));
    endtask

    task automatic send_button(input logic [1:0] idx, input logic pressed);
        send_item(ps2md_pkg::KIND_BUTTON, 8'($urandom), 11'($urandom), idx, pressed);
    endtask

    task automatic send_sync();
        send_item(ps2md_pkg::KIND_SYNC, 8'($urandom), 11'($urandom), 2'($urandom),
                  1'($urandom));
    endtask

    // Stop offering and wait until every expected byte has arrived
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (host_bytes_due.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [10:0] rand_delta();
        int d;
        if ($urandom_range(0, 3) == 0) return 11'($urandom);
        d = $urandom_range(0, 80);
        return 11'(d - 40);
    endfunction

    // ---------------------------------------------------------------
    // Output side: stall pattern, plus a counted hold-off on request
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            if (rx_mode_left <= 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(8, 64);
            end
            rx_mode_left--;
            case (rx_mode)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 3) != 0);
                default: m_tready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Compare each result transaction with the oldest expected byte
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (host_bytes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", m_tdata));
            end else begin
                byte_wanted = host_bytes_due.pop_front();
                if (m_tdata !== byte_wanted.data)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              m_tdata, byte_wanted.data));
                if (m_tuser[0] !== byte_wanted.reply)
                    report_mismatch($sformatf("channel %b, want %b on byte %02h",
                                              m_tuser[0], byte_wanted.reply,
                                              byte_wanted.data));
                if (m_tlast !== byte_wanted.last)
                    report_mismatch($sformatf("tlast %b, want %b on byte %02h",
                                              m_tlast, byte_wanted.last,
                                              byte_wanted.data));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ps2_mouse_device_responder test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Every host command but read-data, both parameter commands, an unknown byte
    task automatic test_host_commands();
        send_cmd(ps2md_pkg::CMD_RESET);
        send_cmd(ps2md_pkg::CMD_GET_ID);
        send_cmd(ps2md_pkg::CMD_STATUS);
        send_cmd(ps2md_pkg::CMD_SET_RES);
        send_cmd(8'hFF);
        send_cmd(ps2md_pkg::CMD_SET_RATE);
        send_cmd(8'h00);
        send_cmd(ps2md_pkg::CMD_STATUS);
        send_cmd(ps2md_pkg::CMD_ENABLE);
        send_cmd(ps2md_pkg::CMD_STATUS);
        send_cmd(ps2md_pkg::CMD_DISABLE);
        send_cmd(ps2md_pkg::CMD_SET_DEFAULTS);
        send_cmd(CMD_UNKNOWN);
    endtask

    // Ignored kinds, bad button index, motion extremes, saturation
    task automatic test_motion_and_buttons();
        send_item(KIND_RESERVED_LO, 8'($urandom), 11'($urandom), 2'($urandom),
                  1'($urandom));
        send_item(KIND_RESERVED_HI, 8'($urandom), 11'($urandom), 2'($urandom),
                  1'($urandom));
        send_button(IDX_INVALID, 1'b1);
        // sync with reporting off still clears the motion
        send_motion(ps2md_pkg::KIND_MOVE_X, DELTA_MAX);
        send_sync();
        send_cmd(ps2md_pkg::CMD_ENABLE);
        send_button(IDX_LEFT, 1'b1);
        send_button(IDX_MIDDLE, 1'b1);
        send_motion(ps2md_pkg::KIND_MOVE_X, DELTA_MIN);
        send_motion(ps2md_pkg::KIND_MOVE_Y, DELTA_MIN);
        // read-data must not touch the accumulated motion
        send_cmd(ps2md_pkg::CMD_READ_DATA);
        send_sync();
        // both axes saturate: the longest packet run
        send_motion(ps2md_pkg::KIND_MOVE_X, DELTA_MAX);
        send_motion(ps2md_pkg::KIND_MOVE_X, DELTA_MAX);
        send_motion(ps2md_pkg::KIND_MOVE_Y, DELTA_MAX);
        send_motion(ps2md_pkg::KIND_MOVE_Y, DELTA_MAX);
        send_sync();
        send_button(IDX_LEFT, 1'b0);
        send_sync();
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        hold_request = 1'b1;
        send_cmd(ps2md_pkg::CMD_ENABLE);
        send_motion(ps2md_pkg::KIND_MOVE_X, DELTA_MAX);
        send_motion(ps2md_pkg::KIND_MOVE_Y, DELTA_MIN);
        send_sync();
        send_cmd(ps2md_pkg::CMD_STATUS);
        send_button(IDX_RIGHT, 1'b1);
        send_cmd(ps2md_pkg::CMD_READ_DATA);
        send_cmd(ps2md_pkg::CMD_GET_ID);
        send_sync();
    endtask

    task automatic random_command(inout int sent);
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0: send_cmd(ps2md_pkg::CMD_RESET);
            1: send_cmd(ps2md_pkg::CMD_DISABLE);
            2: send_cmd(ps2md_pkg::CMD_SET_DEFAULTS);
            3, 4: send_cmd(ps2md_pkg::CMD_ENABLE);
            5, 6: send_cmd(ps2md_pkg::CMD_STATUS);
            7, 8: send_cmd(ps2md_pkg::CMD_READ_DATA);
            9: send_cmd(ps2md_pkg::CMD_GET_ID);
            10: begin
                send_cmd(ps2md_pkg::CMD_SET_RES);
                send_cmd(8'($urandom));
                sent++;
            end
            11: begin
                send_cmd(ps2md_pkg::CMD_SET_RATE);
                send_cmd(8'($urandom));
                sent++;
            end
            default: send_cmd(8'($urandom));
        endcase
        sent++;
        // most of the time turn reporting back on after it was dropped
        if (r <= 2 && $urandom_range(0, 9) < 7) begin
            send_cmd(ps2md_pkg::CMD_ENABLE);
            sent++;
        end
    endtask

    // Mostly motion gestures closed by a sync, some commands and noise
    task automatic test_random_traffic();
        int sent;
        int r;
        sent = 0;
        send_cmd(ps2md_pkg::CMD_ENABLE);
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r <= 6) begin
                repeat ($urandom_range(1, 5)) begin
                    send_motion($urandom_range(0, 1) ? ps2md_pkg::KIND_MOVE_X
                                                     : ps2md_pkg::KIND_MOVE_Y,
                                rand_delta());
                    sent++;
                    if ($urandom_range(0, 9) < 3) begin
                        send_button(2'($urandom_range(IDX_LEFT, IDX_MIDDLE)),
                                    1'($urandom));
                        sent++;
                    end
                end
                send_sync();
                sent++;
            end else if (r <= 8) begin
                random_command(sent);
            end else if ($urandom_range(0, 1)) begin
                send_item(3'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI)),
                          8'($urandom), 11'($urandom), 2'($urandom), 1'($urandom));
                sent++;
            end else begin
                send_button(IDX_INVALID, 1'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        mouse_defaults();
        param_due = ps2md_pkg::PEND_NONE;
        buttons   = '0;
        move_x    = 0;
        move_y    = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_host_commands();
        wait_drain();
        test_motion_and_buttons();
        wait_drain();
        test_backpressure();
        wait_drain();
        test_random_traffic();
        wait_drain();
        repeat (DRAIN_TAIL) @(posedge aclk);

        if (mismatch_count == 0 && host_bytes_due.size() == 0) begin
            $display("ps2_mouse_device_responder test passed");
        end else begin
            $display("ps2_mouse_device_responder test failed");
        end
        $finish;
    end

endmodule

### ps2_mouse_device_responder.f
rtl/ps2md_pkg.sv
rtl/ps2_mouse_device_responder.sv
tb/sv/ps2_mouse_device_responder_tb.sv
